// File: hw/rtl/hcmm_pkg.sv
// Shared types and constants of the handheld console memory map.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package hcmm_pkg;

    localparam int unsigned ADDR_W    = 16;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned IO_IDX_W  = 7;
    localparam int unsigned ROM_BYTES = 32768;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Where the byte returned by a read comes from
    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_MEM,
        SRC_FF,
        SRC_JOY,
        SRC_IO,
        SRC_IE
    } rd_src_t;

    localparam logic [ADDR_W-1:0] VRAM_BASE     = 16'h8000;
    localparam logic [ADDR_W-1:0] ECHO_BASE     = 16'hE000;
    localparam logic [ADDR_W-1:0] OAM_BASE      = 16'hFE00;
    localparam logic [ADDR_W-1:0] UNUSABLE_BASE = 16'hFEA0;
    localparam logic [ADDR_W-1:0] IO_BASE       = 16'hFF00;
    localparam logic [ADDR_W-1:0] HRAM_BASE     = 16'hFF80;
    localparam logic [ADDR_W-1:0] IE_ADDR       = 16'hFFFF;
    localparam logic [ADDR_W-1:0] JOYP_ADDR     = 16'hFF00;
    localparam logic [ADDR_W-1:0] SB_ADDR       = 16'hFF01;
    localparam logic [ADDR_W-1:0] SC_ADDR       = 16'hFF02;
    localparam logic [ADDR_W-1:0] DMA_ADDR      = 16'hFF46;
    localparam logic [2:0]        WRAM_TOP      = 3'b110;

    localparam logic [DATA_W-1:0] SERIAL_START  = 8'h81;
    localparam logic [DATA_W-1:0] OPEN_BUS      = 8'hFF;

    // Decoded request, handed from the decoder to the datapath
    typedef struct packed {
        logic [ADDR_W-1:0]   mem_addr;
        logic                mem_we;
        logic                mem_re;
        rd_src_t             src;
        logic                io_write;
        logic [IO_IDX_W-1:0] io_idx;
        logic                ie_write;
        logic                sb_write;
        logic                joypad_write;
        logic                dma_start;
        logic                serial_emit;
    } decode_t;

    // Power-on contents of the I/O register page
    function automatic logic [DATA_W-1:0] io_power_on(input logic [IO_IDX_W-1:0] idx);
        logic [DATA_W-1:0] v;
        unique case (idx)
            7'h00: v = 8'h0F;
            7'h02: v = 8'h7E;
            7'h03: v = 8'hFF;
            7'h04: v = 8'hAB;
            7'h07: v = 8'hF8;
            7'h10: v = 8'h80;
            7'h11: v = 8'hBF;
            7'h12: v = 8'hF3;
            7'h13: v = 8'hFF;
            7'h14: v = 8'hBF;
            7'h16: v = 8'h3F;
            7'h18: v = 8'hFF;
            7'h19: v = 8'hBF;
            7'h1A: v = 8'h7F;
            7'h1B: v = 8'hFF;
            7'h1C: v = 8'h9F;
            7'h1D: v = 8'hFF;
            7'h1E: v = 8'hBF;
            7'h20: v = 8'hFF;
            7'h23: v = 8'hBF;
            7'h24: v = 8'h77;
            7'h25: v = 8'hF3;
            7'h26: v = 8'hF1;
            7'h40: v = 8'h91;
            7'h41: v = 8'h81;
            7'h44: v = 8'h91;
            7'h46: v = 8'hFF;
            7'h47: v = 8'hFC;
            7'h48: v = 8'hFF;
            7'h49: v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hcmm_if.sv
// Valid/ready channel interfaces: bus requests in, results out.
// Depends on hcmm_pkg for field widths.
`default_nettype none

interface hcmm_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [hcmm_pkg::ADDR_W-1:0]   address;
    logic [hcmm_pkg::DATA_W-1:0]   write_data;
    logic                          dma_active;
    logic [hcmm_pkg::DATA_W-1:0]   joypad_value;

    modport source (output valid, op, address, write_data, dma_active, joypad_value,
                    input ready);
    modport sink   (input valid, op, address, write_data, dma_active, joypad_value,
                    output ready);
endinterface

interface hcmm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hcmm_pkg::DATA_W-1:0]   read_data;
    logic                          joypad_write;
    logic                          dma_start;
    logic                          serial_valid;
    logic [hcmm_pkg::DATA_W-1:0]   serial_byte;

    modport source (output valid, read_data, joypad_write, dma_start, serial_valid,
                    serial_byte, input ready);
    modport sink   (input valid, read_data, joypad_write, dma_start, serial_valid,
                    serial_byte, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hcmm_decode.sv
// Address decoder: turns one bus request into memory controls and side effects.
// Depends on hcmm_pkg.
`default_nettype none

module hcmm_decode (
    input  wire logic [1:0]                  op,
    input  wire logic [hcmm_pkg::ADDR_W-1:0] address,
    input  wire logic [hcmm_pkg::DATA_W-1:0] write_data,
    input  wire logic                        dma_active,
    output hcmm_pkg::decode_t                dec
);

    hcmm_pkg::op_t op_code;

    assign op_code = hcmm_pkg::op_t'(op);

    always_comb
    begin
        dec              = '0;
        dec.src          = hcmm_pkg::SRC_ZERO;
        dec.mem_addr     = address;
        dec.io_idx       = address[hcmm_pkg::IO_IDX_W-1:0];
        unique case (op_code)
            hcmm_pkg::OP_READ:
            begin
                priority if (address < hcmm_pkg::ECHO_BASE)
                begin
                    dec.src    = hcmm_pkg::SRC_MEM;
                    dec.mem_re = 1'b1;
                end
                else if (address < hcmm_pkg::OAM_BASE)
                begin
                    // echo of work RAM
                    dec.mem_addr = {hcmm_pkg::WRAM_TOP, address[12:0]};
                    dec.src      = hcmm_pkg::SRC_MEM;
                    dec.mem_re   = 1'b1;
                end
                else if (address < hcmm_pkg::UNUSABLE_BASE)
                begin
                    dec.src    = dma_active ? hcmm_pkg::SRC_FF : hcmm_pkg::SRC_MEM;
                    dec.mem_re = !dma_active;
                end
                else if (address < hcmm_pkg::IO_BASE)
                begin
                    dec.src = hcmm_pkg::SRC_FF;
                end
                else if (address < hcmm_pkg::HRAM_BASE)
                begin
                    if (address == hcmm_pkg::JOYP_ADDR)
                    begin
                        dec.src = hcmm_pkg::SRC_JOY;
                    end
                    else
                    begin
                        dec.src    = hcmm_pkg::SRC_IO;
                        dec.mem_re = 1'b1;
                    end
                end
                else if (address != hcmm_pkg::IE_ADDR)
                begin
                    dec.src    = hcmm_pkg::SRC_MEM;
                    dec.mem_re = 1'b1;
                end
                else
                begin
                    dec.src = hcmm_pkg::SRC_IE;
                end
            end
            hcmm_pkg::OP_WRITE:
            begin
                priority if (address < hcmm_pkg::VRAM_BASE)
                begin
                    // cartridge ROM ignores bus writes
                end
                else if (address < hcmm_pkg::ECHO_BASE)
                begin
                    dec.mem_we = 1'b1;
                end
                else if (address < hcmm_pkg::OAM_BASE)
                begin
                    dec.mem_addr = {hcmm_pkg::WRAM_TOP, address[12:0]};
                    dec.mem_we   = 1'b1;
                end
                else if (address < hcmm_pkg::UNUSABLE_BASE)
                begin
                    dec.mem_we = !dma_active;
                end
                else if (address < hcmm_pkg::IO_BASE)
                begin
                    // unusable area
                end
                else if (address < hcmm_pkg::HRAM_BASE)
                begin
                    if (address == hcmm_pkg::JOYP_ADDR)
                    begin
                        dec.joypad_write = 1'b1;
                    end
                    else
                    begin
                        dec.io_write    = 1'b1;
                        dec.mem_we      = 1'b1;
                        dec.dma_start   = (address == hcmm_pkg::DMA_ADDR);
                        dec.sb_write    = (address == hcmm_pkg::SB_ADDR);
                        dec.serial_emit = (address == hcmm_pkg::SC_ADDR)
                                          && (write_data == hcmm_pkg::SERIAL_START);
                    end
                end
                else if (address != hcmm_pkg::IE_ADDR)
                begin
                    dec.mem_we = 1'b1;
                end
                else
                begin
                    dec.ie_write = 1'b1;
                end
            end
            hcmm_pkg::OP_LOAD:
            begin
                dec.mem_we = (32'(address) < hcmm_pkg::ROM_BYTES);
            end
            hcmm_pkg::OP_NONE:
            begin
                // no effect
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/hcmm_mem.sv
// Single-port byte memory covering the whole 64 KiB map, registered read.
// Depends on hcmm_pkg for widths.
`default_nettype none

module hcmm_mem (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic                        re,
    input  wire logic [hcmm_pkg::ADDR_W-1:0] addr,
    input  wire logic [hcmm_pkg::DATA_W-1:0] wdata,
    output logic      [hcmm_pkg::DATA_W-1:0] rdata
);

    localparam int unsigned DEPTH = 1 << hcmm_pkg::ADDR_W;

    logic [hcmm_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/handheld_console_memory_map_core.sv
// Memory map core: one request per cycle while the sink keeps up, result in the cycle after acceptance.
// A request is decoded and issued to the single 64 KiB memory in the cycle it is
// accepted; the registered read data and the request's side effects form the
// result register. While that result waits for the sink, new requests are held off,
// since the memory read data must stay put until the result is taken.
// Throughput is one request per cycle while the sink keeps up, bounded by the one
// port of the memory.
// No clearing pass: I/O registers carry valid bits and read their power-on
// values until written; the interrupt-enable byte and serial data sit in flops.
// Depends on hcmm_pkg, hcmm_if, hcmm_decode and hcmm_mem.
`default_nettype none

module handheld_console_memory_map_core (
    input  wire logic clk,
    input  wire logic rst_n,
    hcmm_req_if.sink  req,
    hcmm_rsp_if.source rsp
);

    hcmm_pkg::decode_t dec;
    logic              accept;

    logic                          out_valid_reg;
    logic [127:0]                  io_valid_reg;
    logic [hcmm_pkg::DATA_W-1:0]   ie_reg;
    logic [hcmm_pkg::DATA_W-1:0]   sb_reg;

    hcmm_pkg::rd_src_t             src_reg;
    logic                          io_hit_reg;
    logic [hcmm_pkg::IO_IDX_W-1:0] io_idx_reg;
    logic [hcmm_pkg::DATA_W-1:0]   joy_reg;
    logic [hcmm_pkg::DATA_W-1:0]   ie_snap_reg;
    logic                          joypad_write_reg;
    logic                          dma_start_reg;
    logic                          serial_valid_reg;
    logic [hcmm_pkg::DATA_W-1:0]   serial_byte_reg;
    logic [hcmm_pkg::DATA_W-1:0]   mem_rdata;

    hcmm_decode u_decode (
        .op         (req.op),
        .address    (req.address),
        .write_data (req.write_data),
        .dma_active (req.dma_active),
        .dec        (dec)
    );

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    hcmm_mem u_mem (
        .clk   (clk),
        .we    (accept && dec.mem_we),
        .re    (accept && dec.mem_re),
        .addr  (dec.mem_addr),
        .wdata (req.write_data),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            io_valid_reg  <= '0;
            ie_reg        <= '0;
            sb_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && dec.io_write)
            begin
                io_valid_reg[dec.io_idx] <= 1'b1;
            end
            if (accept && dec.ie_write)
            begin
                ie_reg <= req.write_data;
            end
            if (accept && dec.sb_write)
            begin
                sb_reg <= req.write_data;
            end
        end
    end

    // result payload, loaded only with an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg          <= dec.src;
            io_hit_reg       <= io_valid_reg[dec.io_idx];
            io_idx_reg       <= dec.io_idx;
            joy_reg          <= req.joypad_value;
            ie_snap_reg      <= ie_reg;
            joypad_write_reg <= dec.joypad_write;
            dma_start_reg    <= dec.dma_start;
            serial_valid_reg <= dec.serial_emit;
            serial_byte_reg  <= dec.serial_emit ? sb_reg : '0;
        end
    end

    always_comb
    begin
        unique case (src_reg)
            hcmm_pkg::SRC_MEM: rsp.read_data = mem_rdata;
            hcmm_pkg::SRC_FF:  rsp.read_data = hcmm_pkg::OPEN_BUS;
            hcmm_pkg::SRC_JOY: rsp.read_data = joy_reg;
            hcmm_pkg::SRC_IO:  rsp.read_data = io_hit_reg ? mem_rdata
                                               : hcmm_pkg::io_power_on(io_idx_reg);
            hcmm_pkg::SRC_IE:  rsp.read_data = ie_snap_reg;
            default:           rsp.read_data = '0;
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.joypad_write = joypad_write_reg;
    assign rsp.dma_start    = dma_start_reg;
    assign rsp.serial_valid = serial_valid_reg;
    assign rsp.serial_byte  = serial_byte_reg;

    // at most one side-effect strobe per result
    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({joypad_write_reg, dma_start_reg, serial_valid_reg}))
        else $error("more than one side-effect strobe in a result");

    // reads never raise strobes
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == hcmm_pkg::OP_READ) |=>
            (out_valid_reg && !joypad_write_reg && !dma_start_reg && !serial_valid_reg))
        else $error("read request raised a strobe");

    // joypad write is flagged in the next result
    a_joyp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.op == hcmm_pkg::OP_WRITE && req.address == hcmm_pkg::JOYP_ADDR)
            |=> joypad_write_reg)
        else $error("joypad write not flagged");

    // an empty result register never blocks a request
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("request stalled with empty result register");

endmodule

`default_nettype wire
